FILE: hw/rtl/scb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package scb_pkg;

	localparam int SEGMENTS      = 4;
	localparam int SEGMENT_DEPTH = 1024;
	localparam int SAMPLE_BITS   = 32;

	localparam int SEG_W   = $clog2(SEGMENTS);
	localparam int OFF_W   = $clog2(SEGMENT_DEPTH);
	localparam int FILL_W  = OFF_W + 1;
	localparam int ADDR_W  = SEG_W + OFF_W;
	localparam int CNT_W   = $clog2(SEGMENTS + 1);
	localparam int TRIG_W  = 3;
	localparam int LVL_W   = (CNT_W > TRIG_W) ? CNT_W : TRIG_W;
	localparam int CAP_W   = 11;
	localparam int TOTAL_W = 32;

	// transaction field widths as seen on the ports
	localparam int ACTION_W  = 2;
	localparam int WORD_W    = 32;
	localparam int SELECT_W  = 2;
	localparam int OFFSET_W  = 10;
	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 80;

	typedef enum logic [ACTION_W-1:0] {
		ACT_PUSH     = 2'd0,
		ACT_BEGIN    = 2'd1,
		ACT_COMPLETE = 2'd2,
		ACT_READ     = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		SEG_EMPTY   = 3'd0,
		SEG_FILLING = 3'd1,
		SEG_FULL    = 3'd2,
		SEG_READING = 3'd3,
		SEG_READY   = 3'd4
	} seg_status_t;

	typedef enum logic {
		CFG_CAPACITY = 1'b0,
		CFG_TRIGGER  = 1'b1
	} cfg_index_t;

	typedef seg_status_t    seg_status_arr_t [SEGMENTS];
	typedef logic [FILL_W-1:0] seg_fill_arr_t [SEGMENTS];

endpackage

`default_nettype wire

FILE: hw/rtl/segmented_capture_buffer_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Contents
// s_*       in         tuser[1:0] action; tdata sample_word, success_flag,
//                      segment_select, word_offset
// m_*       out        tdata accepted, segment_out, count_out, data_out,
//                      write_trigger, total_samples
// cfg_*     in         cfg_index 0 segment_capacity, 1 trigger_segments
//
// Push, begin read and complete read settle status, fill and the sample store
// write at the accepting edge.
// Read word registers the sample store read into rd_data_s1 and waits in
// ST_RDWAIT; no new transaction is taken until it leaves ST_RDWAIT.
// The output register frees s_tready as soon as m_tready takes the result.
// arst_n clears all status and counters; the sample store is not cleared,
// since reads are gated by each segment's fill count.
module segmented_capture_buffer_top (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           s_tvalid,
	output logic                          s_tready,
	// [31:0] sample_word, [32] success_flag, [34:33] segment_select,
	// [44:35] word_offset, [47:45] zero
	input  wire  [scb_pkg::S_TDATA_W-1:0] s_tdata,
	// [1:0] action
	input  wire  [scb_pkg::ACTION_W-1:0]  s_tuser,
	output logic                          m_tvalid,
	input  wire                           m_tready,
	// [0] accepted, [2:1] segment_out, [13:3] count_out, [45:14] data_out,
	// [46] write_trigger, [78:47] total_samples, [79] zero
	output logic [scb_pkg::M_TDATA_W-1:0] m_tdata,
	input  wire                           cfg_we,
	input  wire                           cfg_index,
	input  wire  [scb_pkg::CAP_W-1:0]     cfg_data
);
	import scb_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_RDWAIT
	} state_t;

	state_t                  state_q;
	seg_status_arr_t         status_q;
	seg_fill_arr_t           fill_q;
	logic [SEG_W-1:0]        wseg_q;
	logic [SEG_W-1:0]        rseg_q;
	logic                    busy_q;
	logic                    trig_q;
	logic [TOTAL_W-1:0]      total_q;
	logic [CAP_W-1:0]        cap_cfg_q;
	logic [TRIG_W-1:0]       trig_cfg_q;
	logic                    m_tvalid_q;
	logic [M_TDATA_W-1:0]    m_tdata_q;
	logic                    rd_hit_s1;

	logic [SAMPLE_BITS-1:0]  store [SEGMENTS * SEGMENT_DEPTH];
	logic [SAMPLE_BITS-1:0]  rd_data_s1;

	// input fields
	action_t                 action;
	logic [WORD_W-1:0]       sample_word;
	logic                    success_flag;
	logic [SELECT_W-1:0]     segment_select;
	logic [OFFSET_W-1:0]     word_offset;

	assign action         = action_t'(s_tuser);
	assign sample_word    = s_tdata[31:0];
	assign success_flag   = s_tdata[32];
	assign segment_select = s_tdata[34:33];
	assign word_offset    = s_tdata[44:35];

	logic                    out_free;
	logic                    accept;
	logic [FILL_W-1:0]       cap;

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE) && out_free;
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// effective capacity, clamped to 1..SEGMENT_DEPTH
	always_comb begin
		if (cap_cfg_q == '0) begin
			cap = FILL_W'(1);
		end else if (FILL_W'(cap_cfg_q) > FILL_W'(SEGMENT_DEPTH)) begin
			cap = FILL_W'(SEGMENT_DEPTH);
		end else begin
			cap = FILL_W'(cap_cfg_q);
		end
	end

	function automatic logic trig_level(seg_status_arr_t st, logic [TRIG_W-1:0] lvl);
		logic [CNT_W-1:0] n;
		n = '0;
		for (int i = 0; i < SEGMENTS; i++) begin
			if (st[i] == SEG_FULL || st[i] == SEG_FILLING)
				n = n + 1'b1;
		end
		return LVL_W'(n) >= LVL_W'(lvl);
	endfunction

	// priority encoders: lowest EMPTY and lowest FULL segment
	logic             e_found, f_found;
	logic [SEG_W-1:0] e_idx, f_idx;

	always_comb begin
		e_found = 1'b0;
		f_found = 1'b0;
		e_idx   = '0;
		f_idx   = '0;
		for (int i = SEGMENTS - 1; i >= 0; i--) begin
			if (status_q[i] == SEG_EMPTY) begin
				e_found = 1'b1;
				e_idx   = SEG_W'(i);
			end
			if (status_q[i] == SEG_FULL) begin
				f_found = 1'b1;
				f_idx   = SEG_W'(i);
			end
		end
	end

	// next state for one transaction
	seg_status_arr_t     st_n;
	seg_fill_arr_t       fill_n;
	logic [SEG_W-1:0]    wseg_n, rseg_n, ws, nx, rs;
	logic                busy_n, trig_n, ok;
	logic [TOTAL_W-1:0]  total_n;
	logic                acc;
	logic [SEG_W-1:0]    seg_o;
	logic [FILL_W-1:0]   cnt_o;
	logic                mem_we;
	logic [ADDR_W-1:0]   mem_waddr;
	logic                rd_hit;

	always_comb begin
		st_n      = status_q;
		fill_n    = fill_q;
		wseg_n    = wseg_q;
		rseg_n    = rseg_q;
		busy_n    = busy_q;
		trig_n    = trig_q;
		total_n   = total_q;
		acc       = 1'b0;
		seg_o     = '0;
		cnt_o     = '0;
		mem_we    = 1'b0;
		mem_waddr = '0;
		ws        = wseg_q;
		nx        = '0;
		rs        = rseg_q;
		ok        = 1'b1;
		rd_hit    = (32'(segment_select) < 32'(SEGMENTS)) &&
			(FILL_W'(word_offset) < fill_q[SEG_W'(segment_select)]);
		case (action)
			ACT_PUSH: begin
				// current segment unusable: fall back to the lowest EMPTY one
				if (st_n[ws] != SEG_FILLING && st_n[ws] != SEG_EMPTY) begin
					if (!e_found) begin
						ok = 1'b0;
					end else begin
						ws       = e_idx;
						wseg_n   = ws;
						st_n[ws] = SEG_FILLING;
					end
				end
				if (ok && fill_n[ws] >= cap) begin
					nx = (32'(ws) == SEGMENTS - 1) ? '0 : ws + 1'b1;
					if (st_n[nx] != SEG_EMPTY) begin
						ok = 1'b0;
					end else begin
						st_n[ws]   = SEG_FULL;
						wseg_n     = nx;
						st_n[nx]   = SEG_FILLING;
						fill_n[nx] = '0;
						ws         = nx;
					end
				end
				if (ok) begin
					mem_we    = 1'b1;
					mem_waddr = {ws, fill_n[ws][OFF_W-1:0]};
					fill_n[ws] = fill_n[ws] + 1'b1;
					if (st_n[ws] == SEG_EMPTY)
						st_n[ws] = SEG_FILLING;
					if (total_q != '1)
						total_n = total_q + 1'b1;
					if (trig_level(st_n, trig_cfg_q))
						trig_n = 1'b1;
				end
				acc = ok;
			end
			ACT_BEGIN: begin
				if (!busy_q && f_found) begin
					st_n[f_idx] = SEG_READING;
					rseg_n      = f_idx;
					busy_n      = 1'b1;
					acc         = 1'b1;
					seg_o       = f_idx;
					cnt_o       = fill_q[f_idx];
				end
			end
			ACT_COMPLETE: begin
				if (status_q[rs] == SEG_READING) begin
					st_n[rs] = success_flag ? SEG_READY : SEG_FULL;
					acc      = 1'b1;
				end
				rseg_n = '0;
				busy_n = 1'b0;
				if (!trig_level(st_n, trig_cfg_q))
					trig_n = 1'b0;
			end
			default: begin
				// read word: result assembled once the store answers
			end
		endcase
	end

	// sample store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (accept && mem_we)
			store[mem_waddr] <= sample_word[SAMPLE_BITS-1:0];
		if (accept && action == ACT_READ)
			rd_data_s1 <= store[{segment_select[SEG_W-1:0], word_offset[OFF_W-1:0]}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			for (int i = 0; i < SEGMENTS; i++) begin
				status_q[i] <= SEG_EMPTY;
				fill_q[i]   <= '0;
			end
			wseg_q     <= '0;
			rseg_q     <= '0;
			busy_q     <= 1'b0;
			trig_q     <= 1'b0;
			total_q    <= '0;
			cap_cfg_q  <= CAP_W'(1024);
			trig_cfg_q <= TRIG_W'(3);
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			rd_hit_s1  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index_t'(cfg_index))
					CFG_CAPACITY: cap_cfg_q  <= cfg_data;
					CFG_TRIGGER:  trig_cfg_q <= cfg_data[TRIG_W-1:0];
					default:      ;
				endcase
			end
			// result register: loaded by a finished transaction, cleared once taken
			if ((state_q == ST_IDLE && accept && action != ACT_READ) ||
				(state_q == ST_RDWAIT && out_free)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (action == ACT_READ) begin
							rd_hit_s1 <= rd_hit;
							state_q   <= ST_RDWAIT;
						end else begin
							status_q   <= st_n;
							fill_q     <= fill_n;
							wseg_q     <= wseg_n;
							rseg_q     <= rseg_n;
							busy_q     <= busy_n;
							trig_q     <= trig_n;
							total_q    <= total_n;
							m_tdata_q  <= {1'b0, total_n, trig_n, WORD_W'(0),
								cnt_o, seg_o, acc};
						end
					end
				end
				ST_RDWAIT: begin
					// store data stays in rd_data_s1 until the output frees
					if (out_free) begin
						m_tdata_q  <= {1'b0, total_q, trig_q,
							rd_hit_s1 ? WORD_W'(rd_data_s1) : WORD_W'(0),
							FILL_W'(0), SEG_W'(0), rd_hit_s1};
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// the claimed segment stays READING for as long as the read is open
	assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> status_q[rseg_q] == SEG_READING)
		else $error("open read without a READING segment");

	assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (status_q[0] != SEG_READING && status_q[1] != SEG_READING &&
			status_q[2] != SEG_READING && status_q[3] != SEG_READING))
		else $error("READING segment with no open read");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RDWAIT |-> !s_tready)
		else $error("input taken while a store read is pending");

	assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q[0] <= FILL_W'(SEGMENT_DEPTH)) && (fill_q[1] <= FILL_W'(SEGMENT_DEPTH)) &&
		(fill_q[2] <= FILL_W'(SEGMENT_DEPTH)) && (fill_q[3] <= FILL_W'(SEGMENT_DEPTH)))
		else $error("segment fill beyond depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && action == ACT_PUSH && mem_we) |=> total_q != '0)
		else $error("stored sample not counted");

endmodule

`default_nettype wire

FILE: bench/tb_segmented_capture_buffer_top.sv
`timescale 1ns / 1ps

module tb_segmented_capture_buffer_top;
	import scb_pkg::*;

	// one result transaction, laid out as m_tdata[78:0] from the highest bit down
	typedef struct packed {
		logic [TOTAL_W-1:0] total;
		logic               trig;
		logic [WORD_W-1:0]  data;
		logic [FILL_W-1:0]  cnt;
		logic [SEG_W-1:0]   seg;
		logic               acc;
	} outcome_t;

	// a directed row is either a register write or a transaction
	typedef struct {
		bit                is_cfg;
		cfg_index_t        reg_sel;
		logic [CAP_W-1:0]  reg_val;
		action_t           act;
		logic [WORD_W-1:0] word;
		logic              succ;
		logic [SELECT_W-1:0] sel;
		logic [OFFSET_W-1:0] off;
		bit                typed;
		outcome_t          want;
	} stim_row_t;

	localparam int DIRECTED_ROWS = 27;
	localparam int PHASE_ITEMS   = 425;

	localparam outcome_t QUIET    = '0;
	localparam outcome_t ONE_SEEN = '{total: 32'd1, default: '0};
	localparam outcome_t ONE_PUSH = '{acc: 1'b1, total: 32'd1, default: '0};
	localparam outcome_t TOP_WORD = '{acc: 1'b1, data: 32'hFFFF_FFFF, total: 32'd1,
		default: '0};

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	logic [ACTION_W-1:0]  s_tuser  = ACT_PUSH;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 cfg_we    = 1'b0;
	logic                 cfg_index = CFG_CAPACITY;
	logic [CAP_W-1:0]     cfg_data  = '0;

	segmented_capture_buffer_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #4 clk = ~clk;

	// mirror of the buffer state
	seg_status_t       seg_state [SEGMENTS];
	logic [FILL_W-1:0] seg_fill  [SEGMENTS];
	logic [WORD_W-1:0] sample_mem [SEGMENTS*SEGMENT_DEPTH];
	int                wr_seg;
	int                rd_seg;
	bit                rd_claimed;
	bit                trig_raised;
	logic [TOTAL_W-1:0] sample_count;
	logic [CAP_W-1:0]  cap_setting;
	logic [TRIG_W-1:0] trig_setting;

	outcome_t  outcomes_due [$];
	int        mismatch_count = 0;
	int        txn_count = 0;
	int        burst_left = 0;
	stim_row_t directed [DIRECTED_ROWS];

	function automatic int lowest_segment_in(seg_status_t st);
		for (int i = 0; i < SEGMENTS; i++)
			if (seg_state[i] == st)
				return i;
		return -1;
	endfunction

	function automatic bit level_reached();
		int n;
		n = 0;
		for (int i = 0; i < SEGMENTS; i++)
			if (seg_state[i] == SEG_FULL || seg_state[i] == SEG_FILLING)
				n++;
		return n >= trig_setting;
	endfunction

	// applies one transaction to the mirror and returns the result it yields
	function automatic outcome_t capture_outcome(action_t act, logic [WORD_W-1:0] word,
			logic succ, logic [SELECT_W-1:0] sel, logic [OFFSET_W-1:0] off);
		outcome_t r;
		int       cap;
		int       ws;
		int       nx;
		int       f;
		bit       ok;
		r = '0;
		case (act)
			ACT_PUSH: begin
				ok  = 1'b1;
				cap = (cap_setting == 0) ? 1 :
					(cap_setting > SEGMENT_DEPTH) ? SEGMENT_DEPTH : int'(cap_setting);
				ws  = wr_seg;
				if (seg_state[ws] != SEG_FILLING && seg_state[ws] != SEG_EMPTY) begin
					f = lowest_segment_in(SEG_EMPTY);
					if (f < 0) begin
						ok = 1'b0;
					end else begin
						ws = f;
						wr_seg = f;
						seg_state[ws] = SEG_FILLING;
					end
				end
				// segment full: move on only into an empty neighbour
				if (ok && seg_fill[ws] >= cap) begin
					nx = (ws + 1) % SEGMENTS;
					if (seg_state[nx] != SEG_EMPTY) begin
						ok = 1'b0;
					end else begin
						seg_state[ws] = SEG_FULL;
						wr_seg = nx;
						seg_state[nx] = SEG_FILLING;
						seg_fill[nx] = '0;
						if (level_reached())
							trig_raised = 1'b1;
						ws = nx;
					end
				end
				if (ok) begin
					sample_mem[ws*SEGMENT_DEPTH + seg_fill[ws]] = word;
					seg_fill[ws]++;
					if (seg_state[ws] == SEG_EMPTY)
						seg_state[ws] = SEG_FILLING;
					if (sample_count != '1)
						sample_count++;
					if (level_reached())
						trig_raised = 1'b1;
				end
				r.acc = ok;
			end
			ACT_BEGIN: begin
				if (!rd_claimed) begin
					f = lowest_segment_in(SEG_FULL);
					if (f >= 0) begin
						seg_state[f] = SEG_READING;
						rd_seg = f;
						rd_claimed = 1'b1;
						r.acc = 1'b1;
						r.seg = SEG_W'(f);
						r.cnt = seg_fill[f];
					end
				end
			end
			ACT_COMPLETE: begin
				if (seg_state[rd_seg] == SEG_READING) begin
					seg_state[rd_seg] = succ ? SEG_READY : SEG_FULL;
					r.acc = 1'b1;
				end
				// busy and read pointer clear even with nothing in READING
				rd_seg = 0;
				rd_claimed = 1'b0;
				if (!level_reached())
					trig_raised = 1'b0;
			end
			default: begin
				if (sel < SEGMENTS && off < seg_fill[sel]) begin
					r.acc  = 1'b1;
					r.data = sample_mem[sel*SEGMENT_DEPTH + off];
				end
			end
		endcase
		r.trig  = trig_raised;
		r.total = sample_count;
		return r;
	endfunction

	// offers one transaction from a falling edge; returns at the falling edge after
	// acceptance with tvalid still high
	task automatic send_txn(action_t act, logic [WORD_W-1:0] word, logic succ,
			logic [SELECT_W-1:0] sel, logic [OFFSET_W-1:0] off, bit typed, outcome_t want);
		outcome_t r;
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {3'b000, off, sel, succ, word};
		do @(posedge clk); while (!s_tready);
		r = capture_outcome(act, word, succ, sel, off);
		outcomes_due.push_back(typed ? want : r);
		txn_count++;
		@(negedge clk);
	endtask

	// bursts of random length, mostly with a random gap after each
	task automatic pace();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			if ($urandom_range(0, 3) != 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end
			burst_left = $urandom_range(0, 30);
		end
	endtask

	// registers change only with nothing in flight
	task automatic write_register(cfg_index_t idx, logic [CAP_W-1:0] val);
		s_tvalid <= 1'b0;
		while (outcomes_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
		if (idx == CFG_CAPACITY)
			cap_setting = val;
		else
			trig_setting = val[TRIG_W-1:0];
	endtask

	task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h got %h", $time, what, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin
		outcome_t got;
		outcome_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[78:0];
			if (outcomes_due.size() == 0) begin
				$display("%0t: unexpected result transaction, expected none got %h",
					$time, got);
				mismatch_count++;
			end else begin
				want = outcomes_due.pop_front();
				check_field("accepted", 32'(want.acc), 32'(got.acc));
				check_field("segment_out", 32'(want.seg), 32'(got.seg));
				check_field("count_out", 32'(want.cnt), 32'(got.cnt));
				check_field("data_out", want.data, got.data);
				check_field("write_trigger", 32'(want.trig), 32'(got.trig));
				check_field("total_samples", want.total, got.total);
			end
		end
	end

	// result side: stall patterns of random style and length, plus one long hold
	// while the sender keeps offering, so the buffer backs up into s_tready
	initial begin : receiver
		int span;
		int style;
		bit held;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held && txn_count >= 600) begin
				held = 1'b1;
				@(negedge clk);
				m_tready <= 1'b0;
				repeat (300) @(negedge clk);
			end
			style = $urandom_range(0, 3);
			span  = $urandom_range(1, 40);
			repeat (span) begin
				@(negedge clk);
				case (style)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'b0;
					2: m_tready <= 1'($urandom_range(0, 1));
					default: m_tready <= ~m_tready;
				endcase
			end
		end
	end

	initial begin
		#(5_000_000);
		$display("segmented_capture_buffer_top verification failed");
		$finish;
	end

	initial begin
		int               phase_cap  [4];
		int               phase_trig [4];
		int               pick;
		int               s;
		action_t          act;
		logic [WORD_W-1:0] word;
		logic             succ;
		logic [SELECT_W-1:0] sel;
		logic [OFFSET_W-1:0] off;

		for (int i = 0; i < SEGMENTS; i++) begin
			seg_state[i] = SEG_EMPTY;
			seg_fill[i]  = '0;
		end
		wr_seg       = 0;
		rd_seg       = 0;
		rd_claimed   = 1'b0;
		trig_raised  = 1'b0;
		sample_count = '0;
		cap_setting  = 11'd1024;
		trig_setting = 3'd3;

		// fresh state first, then a capacity of one so every push walks a segment
		directed[0]  = '{1'b0, CFG_CAPACITY, 11'd0, ACT_READ, 32'h0, 1'b0, 2'd0, 10'd0,
			1'b1, QUIET};
		directed[1]  = '{1'b0, CFG_CAPACITY, 11'd0, ACT_BEGIN, 32'h0, 1'b0, 2'd0, 10'd0,
			1'b1, QUIET};
		directed[2]  = '{1'b0, CFG_CAPACITY, 11'd0, ACT_COMPLETE, 32'h0, 1'b1, 2'd0, 10'd0,
			1'b1, QUIET};
		directed[3]  = '{1'b0, CFG_CAPACITY, 11'd0, ACT_PUSH, 32'hFFFF_FFFF, 1'b0, 2'd0,
			10'd0, 1'b1, ONE_PUSH};
		directed[4]  = '{1'b0, CFG_CAPACITY, 11'd0, ACT_READ, 32'h0, 1'b0, 2'd0, 10'd0,
			1'b1, TOP_WORD};
		directed[5]  = '{1'b0, CFG_CAPACITY, 11'd0, ACT_READ, 32'h0, 1'b0, 2'd0, 10'd1,
			1'b1, ONE_SEEN};
		directed[6]  = '{1'b0, CFG_CAPACITY, 11'd0, ACT_READ, 32'h0, 1'b0, 2'd3, 10'd1023,
			1'b1, ONE_SEEN};
		// capacity zero behaves as one
		directed[7]  = '{1'b1, CFG_CAPACITY, 11'd0, ACT_PUSH, 32'h0, 1'b0, 2'd0, 10'd0,
			1'b0, QUIET};
		directed[8]  = '{1'b1, CFG_TRIGGER, 11'd1, ACT_PUSH, 32'h0, 1'b0, 2'd0, 10'd0,
			1'b0, QUIET};
		directed[9]  = '{1'b0, CFG_CAPACITY, 11'd0, ACT_PUSH, 32'h0, 1'b0, 2'd0, 10'd0,
			1'b0, QUIET};
		directed[10] = '{1'b0, CFG_CAPACITY, 11'd0, ACT_BEGIN, 32'h0, 1'b0, 2'd0, 10'd0,
			1'b0, QUIET};
		// second claim while busy
		directed[11] = '{1'b0, CFG_CAPACITY, 11'd0, ACT_BEGIN, 32'h0, 1'b0, 2'd0, 10'd0,
			1'b0, QUIET};
		directed[12] = '{1'b0, CFG_CAPACITY, 11'd0, ACT_COMPLETE, 32'h0, 1'b0, 2'd0, 10'd0,
			1'b0, QUIET};
		// completion with nothing being read
		directed[13] = '{1'b0, CFG_CAPACITY, 11'd0, ACT_COMPLETE, 32'h0, 1'b1, 2'd0, 10'd0,
			1'b0, QUIET};
		directed[14] = '{1'b0, CFG_CAPACITY, 11'd0, ACT_PUSH, 32'hA5A5_A5A5, 1'b0, 2'd0,
			10'd0, 1'b0, QUIET};
		directed[15] = '{1'b0, CFG_CAPACITY, 11'd0, ACT_PUSH, 32'h5A5A_5A5A, 1'b0, 2'd0,
			10'd0, 1'b0, QUIET};
		// wrapped round onto a non-empty segment: rejected
		directed[16] = '{1'b0, CFG_CAPACITY, 11'd0, ACT_PUSH, 32'h0F0F_0F0F, 1'b0, 2'd0,
			10'd0, 1'b0, QUIET};
		directed[17] = '{1'b0, CFG_CAPACITY, 11'd0, ACT_READ, 32'h0, 1'b0, 2'd3, 10'd0,
			1'b0, QUIET};
		// trigger level zero holds the flag, above SEGMENTS it drops
		directed[18] = '{1'b1, CFG_TRIGGER, 11'd0, ACT_PUSH, 32'h0, 1'b0, 2'd0, 10'd0,
			1'b0, QUIET};
		directed[19] = '{1'b0, CFG_CAPACITY, 11'd0, ACT_COMPLETE, 32'h0, 1'b0, 2'd0, 10'd0,
			1'b0, QUIET};
		directed[20] = '{1'b1, CFG_TRIGGER, 11'd5, ACT_PUSH, 32'h0, 1'b0, 2'd0, 10'd0,
			1'b0, QUIET};
		directed[21] = '{1'b0, CFG_CAPACITY, 11'd0, ACT_COMPLETE, 32'h0, 1'b0, 2'd0, 10'd0,
			1'b0, QUIET};
		// capacity above the depth clamps to the depth
		directed[22] = '{1'b1, CFG_CAPACITY, 11'd2047, ACT_PUSH, 32'h0, 1'b0, 2'd0, 10'd0,
			1'b0, QUIET};
		directed[23] = '{1'b0, CFG_CAPACITY, 11'd0, ACT_PUSH, 32'h8000_0001, 1'b0, 2'd0,
			10'd0, 1'b0, QUIET};
		directed[24] = '{1'b0, CFG_CAPACITY, 11'd0, ACT_READ, 32'h0, 1'b0, 2'd3, 10'd1,
			1'b0, QUIET};
		directed[25] = '{1'b0, CFG_CAPACITY, 11'd0, ACT_BEGIN, 32'h0, 1'b0, 2'd0, 10'd0,
			1'b0, QUIET};
		directed[26] = '{1'b0, CFG_CAPACITY, 11'd0, ACT_COMPLETE, 32'h0, 1'b1, 2'd0, 10'd0,
			1'b0, QUIET};

		phase_cap  = '{400, 1, 900, 1024};
		phase_trig = '{2, 7, 4, 3};

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed[i]) begin
			if (directed[i].is_cfg) begin
				write_register(directed[i].reg_sel, directed[i].reg_val);
			end else begin
				send_txn(directed[i].act, directed[i].word, directed[i].succ,
					directed[i].sel, directed[i].off, directed[i].typed, directed[i].want);
				pace();
			end
		end

		for (int p = 0; p < 4; p++) begin
			write_register(CFG_CAPACITY, CAP_W'(phase_cap[p]));
			write_register(CFG_TRIGGER, CAP_W'(phase_trig[p]));
			repeat (PHASE_ITEMS) begin
				word = $urandom;
				succ = ($urandom_range(0, 24) == 0);
				sel  = SELECT_W'($urandom_range(0, SEGMENTS - 1));
				off  = OFFSET_W'($urandom_range(0, SEGMENT_DEPTH - 1));
				pick = $urandom_range(0, 99);
				if (pick < 40) begin
					act = ACT_PUSH;
				end else if (pick < 52) begin
					act = ACT_BEGIN;
				end else if (pick < 64) begin
					act = ACT_COMPLETE;
				end else begin
					act = ACT_READ;
					// mostly aim at stored words, the rest anywhere
					if (pick < 90) begin
						s = $urandom_range(0, SEGMENTS - 1);
						sel = SELECT_W'(s);
						if (seg_fill[s] != 0)
							off = OFFSET_W'($urandom_range(0, seg_fill[s] - 1));
					end
				end
				send_txn(act, word, succ, sel, off, 1'b0, QUIET);
				pace();
			end
		end

		s_tvalid <= 1'b0;
		while (outcomes_due.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && outcomes_due.size() == 0) begin
			$display("segmented_capture_buffer_top verification clean");
		end else begin
			$display("segmented_capture_buffer_top verification failed");
		end
		$finish;
	end

endmodule
